// ===== hdl/iirl_pkg.sv =====
// types, constants and codes shared by the indexed list unit
`timescale 1ns / 1ps

package iirl_pkg;

  localparam int IIRL_CAPACITY = 16;

  localparam logic [7:0] EMPTY_PIECE = 8'h00;
  localparam logic [3:0] EMPTY_COORD = 4'hF;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CTL_IDLE = 2'b01,
    CTL_HOLD = 2'b10
  } ctl_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [4:0] index;
    logic [7:0] piece;
    logic [2:0] from_row;
    logic [2:0] from_col;
    logic [2:0] to_row;
    logic [2:0] to_col;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [4:0]        count;
    logic              is_full;
    logic              is_empty;
    logic [7:0]        read_piece;
    logic signed [3:0] read_from_row;
    logic signed [3:0] read_from_col;
    logic signed [3:0] read_to_row;
    logic signed [3:0] read_to_col;
  } out_item_t;

  typedef struct packed {
    logic exec;
  } ctl_cmd_t;

endpackage

// ===== hdl/iirl_ctrl.sv =====
// handshake controller: accepts an item and holds the result until taken
`timescale 1ns / 1ps

module iirl_ctrl import iirl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  // stall input only while an untaken result blocks the output register
  assign in_stall  = (state_r == CTL_HOLD) && out_stall;
  assign out_valid = (state_r == CTL_HOLD);
  assign cmd.exec  = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CTL_IDLE: begin
        if (cmd.exec) state_nxt = CTL_HOLD;
      end
      CTL_HOLD: begin
        if (cmd.exec) state_nxt = CTL_HOLD;
        else if (!out_stall) state_nxt = CTL_IDLE;
      end
      default: state_nxt = CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= CTL_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ===== hdl/iirl_dpath.sv =====
// list storage with parallel shift, status logic and result register
`timescale 1ns / 1ps

module iirl_dpath import iirl_pkg::*; #(
  parameter int CAPACITY = IIRL_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_cmd_t  cmd,
  input  in_item_t  in_item,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int AW    = $clog2(CAPACITY);

  logic [7:0] piece_r  [CAPACITY];
  logic [3:0] frow_r   [CAPACITY];
  logic [3:0] fcol_r   [CAPACITY];
  logic [3:0] trow_r   [CAPACITY];
  logic [3:0] tcol_r   [CAPACITY];
  logic [7:0] piece_nxt[CAPACITY];
  logic [3:0] frow_nxt [CAPACITY];
  logic [3:0] fcol_nxt [CAPACITY];
  logic [3:0] trow_nxt [CAPACITY];
  logic [3:0] tcol_nxt [CAPACITY];

  logic [CNT_W-1:0] count_r, count_nxt;
  out_item_t        out_r, out_nxt;

  logic [CMP_W-1:0] idx_ext, cnt_ext, rm_pos, cnt_out_ext;
  logic [AW-1:0]    rd_addr;
  logic             ins_ok, rm_ok, rd_ok;
  status_t          status;

  assign idx_ext = CMP_W'(in_item.index);
  assign cnt_ext = CMP_W'(count_r);
  assign rd_addr = idx_ext[AW-1:0];

  // slots at and above the count always hold empty markers
  assign ins_ok = (idx_ext <= cnt_ext) && (cnt_ext < CMP_W'(CAPACITY));
  assign rm_ok  = (idx_ext <= cnt_ext) && (cnt_ext != '0);
  assign rd_ok  = (idx_ext < cnt_ext);
  // an index equal to the count removes the last entry
  assign rm_pos = (idx_ext == cnt_ext) ? cnt_ext - CMP_W'(1) : idx_ext;

  always_comb begin
    status    = ST_OK;
    count_nxt = count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      piece_nxt[i] = piece_r[i];
      frow_nxt[i]  = frow_r[i];
      fcol_nxt[i]  = fcol_r[i];
      trow_nxt[i]  = trow_r[i];
      tcol_nxt[i]  = tcol_r[i];
    end
    case (in_item.kind)
      KIND_INSERT: begin
        if (idx_ext > cnt_ext) status = ST_INVALID;
        else if (!ins_ok) status = ST_FULL;
        else begin
          count_nxt = count_r + CNT_W'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            if (CMP_W'(i) == idx_ext) begin
              piece_nxt[i] = in_item.piece;
              frow_nxt[i]  = {1'b0, in_item.from_row};
              fcol_nxt[i]  = {1'b0, in_item.from_col};
              trow_nxt[i]  = {1'b0, in_item.to_row};
              tcol_nxt[i]  = {1'b0, in_item.to_col};
            end else if (i > 0 && CMP_W'(i) > idx_ext) begin
              piece_nxt[i] = piece_r[i-1];
              frow_nxt[i]  = frow_r[i-1];
              fcol_nxt[i]  = fcol_r[i-1];
              trow_nxt[i]  = trow_r[i-1];
              tcol_nxt[i]  = tcol_r[i-1];
            end
          end
        end
      end
      KIND_REMOVE: begin
        if (idx_ext > cnt_ext) status = ST_INVALID;
        else if (!rm_ok) status = ST_EMPTY;
        else begin
          count_nxt = count_r - CNT_W'(1);
          for (int i = 0; i < CAPACITY; i++) begin
            if (CMP_W'(i) >= rm_pos) begin
              if (i == CAPACITY - 1) begin
                piece_nxt[i] = EMPTY_PIECE;
                frow_nxt[i]  = EMPTY_COORD;
                fcol_nxt[i]  = EMPTY_COORD;
                trow_nxt[i]  = EMPTY_COORD;
                tcol_nxt[i]  = EMPTY_COORD;
              end else begin
                piece_nxt[i] = piece_r[i+1];
                frow_nxt[i]  = frow_r[i+1];
                fcol_nxt[i]  = fcol_r[i+1];
                trow_nxt[i]  = trow_r[i+1];
                tcol_nxt[i]  = tcol_r[i+1];
              end
            end
          end
        end
      end
      KIND_CLEAR: begin
        count_nxt = '0;
        for (int i = 0; i < CAPACITY; i++) begin
          piece_nxt[i] = EMPTY_PIECE;
          frow_nxt[i]  = EMPTY_COORD;
          fcol_nxt[i]  = EMPTY_COORD;
          trow_nxt[i]  = EMPTY_COORD;
          tcol_nxt[i]  = EMPTY_COORD;
        end
      end
      KIND_READ: begin
        if (!rd_ok) status = ST_INVALID;
      end
      default: status = ST_INVALID;
    endcase
  end

  assign cnt_out_ext = CMP_W'(count_nxt);

  always_comb begin
    out_nxt.status        = status;
    out_nxt.count         = cnt_out_ext[4:0];
    out_nxt.is_full       = (count_nxt == CNT_W'(CAPACITY));
    out_nxt.is_empty      = (count_nxt == '0);
    out_nxt.read_piece    = EMPTY_PIECE;
    out_nxt.read_from_row = EMPTY_COORD;
    out_nxt.read_from_col = EMPTY_COORD;
    out_nxt.read_to_row   = EMPTY_COORD;
    out_nxt.read_to_col   = EMPTY_COORD;
    if (in_item.kind == KIND_READ && rd_ok) begin
      out_nxt.read_piece    = piece_r[rd_addr];
      out_nxt.read_from_row = frow_r[rd_addr];
      out_nxt.read_from_col = fcol_r[rd_addr];
      out_nxt.read_to_row   = trow_r[rd_addr];
      out_nxt.read_to_col   = tcol_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        piece_r[i] <= EMPTY_PIECE;
        frow_r[i]  <= EMPTY_COORD;
        fcol_r[i]  <= EMPTY_COORD;
        trow_r[i]  <= EMPTY_COORD;
        tcol_r[i]  <= EMPTY_COORD;
      end
    end else if (cmd.exec) begin
      count_r <= count_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        piece_r[i] <= piece_nxt[i];
        frow_r[i]  <= frow_nxt[i];
        fcol_r[i]  <= fcol_nxt[i];
        trow_r[i]  <= trow_nxt[i];
        tcol_r[i]  <= tcol_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) out_r <= out_nxt;
  end

  assign out_item = out_r;

endmodule

// ===== hdl/indexed_insert_remove_list_unit.sv =====
// top level of the indexed insert/remove list unit
//
//   channel   ports                           direction  carries
//   input     in_valid, in_stall, in_data     in         operation, index, entry
//   result    out_valid, out_stall, out_data  out        status, count, flags, read entry
//
// each accepted item is executed in the cycle of its transfer: the list
// shifts all slots in parallel and the result lands in the output register,
// so one item per cycle is sustained while results are taken
// synchronous active-low reset empties the list (count zero, empty markers)
// a stalled result holds the output register and stalls the input side only
// while the result is waiting
`timescale 1ns / 1ps

module indexed_insert_remove_list_unit import iirl_pkg::*; #(
  parameter int CAPACITY = IIRL_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctl_cmd_t cmd;

  // handshake and result-register occupancy
  iirl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // slot registers, shift network and result register
  iirl_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_data),
    .out_item (out_data)
  );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the indexed insert/remove list unit
`timescale 1ns / 1ps

module tb;
  import iirl_pkg::*;

  localparam int CAP = IIRL_CAPACITY;
  // cycles with no transfer on either side before the run is abandoned
  localparam int STUCK_LIMIT = 1000;

  // one stored entry as the list keeps it, coordinates widened to 4 bits
  typedef struct packed {
    logic [7:0] piece;
    logic [3:0] from_row;
    logic [3:0] from_col;
    logic [3:0] to_row;
    logic [3:0] to_col;
  } move_slot_t;

  localparam move_slot_t BLANK_SLOT = '{
    piece: EMPTY_PIECE, from_row: EMPTY_COORD, from_col: EMPTY_COORD,
    to_row: EMPTY_COORD, to_col: EMPTY_COORD
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // shadow copy of the list, updated at every input transfer
  move_slot_t  list_slots [CAP];
  int unsigned list_len;

  // results still owed by the block, oldest first
  out_item_t expected_results [$];
  out_item_t want_res;

  // random idling on the two sides, switched off for the back-to-back stretch
  bit idling_on = 1'b1;
  bit stalling_on = 1'b1;

  int error_count = 0;
  int ops_sent = 0;
  int results_checked = 0;
  int peak_len = 0;
  int status_tally [4] = '{default: 0};
  int stuck_cycles = 0;

  indexed_insert_remove_list_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one accepted operation to the shadow list and return its result
  function automatic out_item_t apply_list_op(in_item_t op);
    out_item_t res;
    int i;
    res = '0;
    res.status = ST_OK;
    res.read_piece = EMPTY_PIECE;
    res.read_from_row = EMPTY_COORD;
    res.read_from_col = EMPTY_COORD;
    res.read_to_row = EMPTY_COORD;
    res.read_to_col = EMPTY_COORD;
    case (op.kind)
      KIND_INSERT: begin
        // position check wins over the capacity check
        if (op.index > list_len) begin
          res.status = ST_INVALID;
        end else if (list_len >= CAP) begin
          res.status = ST_FULL;
        end else begin
          for (i = list_len; i > op.index; i--) list_slots[i] = list_slots[i - 1];
          list_slots[op.index] = '{
            piece: op.piece, from_row: {1'b0, op.from_row}, from_col: {1'b0, op.from_col},
            to_row: {1'b0, op.to_row}, to_col: {1'b0, op.to_col}
          };
          list_len++;
        end
      end
      KIND_REMOVE: begin
        // index equal to a nonzero length drops the last entry
        if (op.index > list_len) begin
          res.status = ST_INVALID;
        end else if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          for (i = op.index; i + 1 < list_len; i++) list_slots[i] = list_slots[i + 1];
          list_slots[list_len - 1] = BLANK_SLOT;
          list_len--;
        end
      end
      KIND_CLEAR: begin
        for (i = 0; i < CAP; i++) list_slots[i] = BLANK_SLOT;
        list_len = 0;
      end
      default: begin
        if (op.index >= list_len) begin
          res.status = ST_INVALID;
        end else begin
          res.read_piece = list_slots[op.index].piece;
          res.read_from_row = list_slots[op.index].from_row;
          res.read_from_col = list_slots[op.index].from_col;
          res.read_to_row = list_slots[op.index].to_row;
          res.read_to_col = list_slots[op.index].to_col;
        end
      end
    endcase
    res.count = list_len[4:0];
    res.is_full = (list_len == CAP);
    res.is_empty = (list_len == 0);
    status_tally[res.status]++;
    if (list_len > peak_len) peak_len = list_len;
    return res;
  endfunction

  // operation with random entry content
  function automatic in_item_t random_entry(kind_t kind, logic [4:0] idx);
    in_item_t op;
    op.kind = kind;
    op.index = idx;
    op.piece = 8'($urandom_range(255));
    op.from_row = 3'($urandom_range(7));
    op.from_col = 3'($urandom_range(7));
    op.to_row = 3'($urandom_range(7));
    op.to_col = 3'($urandom_range(7));
    return op;
  endfunction

  // operation with a fixed piece and one fixed value for all four coordinates
  function automatic in_item_t fixed_entry(kind_t kind, logic [4:0] idx, logic [7:0] piece,
                                           logic [2:0] coord);
    in_item_t op;
    op = '{kind: kind, index: idx, piece: piece, from_row: coord, from_col: coord,
           to_row: coord, to_col: coord};
    return op;
  endfunction

  // random operation; weights in percent, clear takes the remainder
  // most indexes land inside the list, some anywhere in the 5-bit field
  function automatic in_item_t pick_op(int ins_w, int rem_w, int rd_w);
    in_item_t op;
    kind_t kind;
    int roll;
    roll = $urandom_range(99);
    if (roll < ins_w) kind = KIND_INSERT;
    else if (roll < ins_w + rem_w) kind = KIND_REMOVE;
    else if (roll < ins_w + rem_w + rd_w) kind = KIND_READ;
    else kind = KIND_CLEAR;
    op = random_entry(kind, '0);
    if ($urandom_range(99) < 15) op.index = 5'($urandom_range(31));
    else if (kind == KIND_READ && list_len > 0) op.index = 5'($urandom_range(list_len - 1));
    else op.index = 5'($urandom_range(list_len));
    return op;
  endfunction

  // one input transfer: optional idle cycles, then hold until accepted
  task automatic send_op(input in_item_t op);
    while (idling_on && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(apply_list_op(op));
    ops_sent++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // result side: random stalls, and every result transfer checked in order
  always @(posedge clk) begin
    out_stall <= stalling_on && ($urandom_range(99) < 16);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no operation outstanding");
        error_count++;
      end else begin
        want_res = expected_results.pop_front();
        check_field("status", 32'(want_res.status), 32'(out_data.status));
        check_field("count", 32'(want_res.count), 32'(out_data.count));
        check_field("is_full", 32'(want_res.is_full), 32'(out_data.is_full));
        check_field("is_empty", 32'(want_res.is_empty), 32'(out_data.is_empty));
        check_field("read_piece", 32'(want_res.read_piece), 32'(out_data.read_piece));
        check_field("read_from_row", 32'(want_res.read_from_row),
                    32'(out_data.read_from_row));
        check_field("read_from_col", 32'(want_res.read_from_col),
                    32'(out_data.read_from_col));
        check_field("read_to_row", 32'(want_res.read_to_row), 32'(out_data.read_to_row));
        check_field("read_to_col", 32'(want_res.read_to_col), 32'(out_data.read_to_col));
        results_checked++;
      end
    end
  end

  // watchdog: too long without a transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // fresh list: reads, removes and out-of-range inserts all refused, then a clear
  task automatic test_empty_list();
    send_op(fixed_entry(KIND_READ, 5'd0, 8'h00, 3'd0));
    send_op(fixed_entry(KIND_READ, 5'd31, 8'h00, 3'd0));
    send_op(fixed_entry(KIND_REMOVE, 5'd0, 8'h00, 3'd0));
    send_op(fixed_entry(KIND_REMOVE, 5'd1, 8'h00, 3'd0));
    send_op(fixed_entry(KIND_INSERT, 5'd1, 8'hFF, 3'd7));
    send_op(fixed_entry(KIND_CLEAR, 5'd0, 8'h00, 3'd0));
  endtask

  // field extremes, shifting both ways, remove at the end, clear with entries
  task automatic test_edge_entries();
    send_op(fixed_entry(KIND_INSERT, 5'd0, 8'hFF, 3'd7));
    send_op(fixed_entry(KIND_INSERT, 5'd1, 8'h00, 3'd0));
    send_op(fixed_entry(KIND_INSERT, 5'd0, 8'hA5, 3'd5));
    send_op(fixed_entry(KIND_READ, 5'd0, 8'h00, 3'd0));
    send_op(fixed_entry(KIND_READ, 5'd1, 8'h00, 3'd0));
    send_op(fixed_entry(KIND_READ, 5'd2, 8'h00, 3'd0));
    // read at the length itself
    send_op(fixed_entry(KIND_READ, 5'd3, 8'h00, 3'd0));
    // insert beyond the end
    send_op(fixed_entry(KIND_INSERT, 5'd5, 8'h5A, 3'd2));
    // remove at the length takes the last entry
    send_op(fixed_entry(KIND_REMOVE, 5'd3, 8'h00, 3'd0));
    send_op(fixed_entry(KIND_READ, 5'd2, 8'h00, 3'd0));
    send_op(fixed_entry(KIND_REMOVE, 5'd0, 8'h00, 3'd0));
    send_op(fixed_entry(KIND_REMOVE, 5'd31, 8'h00, 3'd0));
    send_op(fixed_entry(KIND_READ, 5'd0, 8'h00, 3'd0));
    send_op(fixed_entry(KIND_CLEAR, 5'd9, 8'hFF, 3'd7));
    send_op(fixed_entry(KIND_READ, 5'd0, 8'h00, 3'd0));
  endtask

  // fill to capacity, then the full and out-of-range cases against it
  task automatic test_full_list();
    while (list_len < CAP) send_op(random_entry(KIND_INSERT, 5'($urandom_range(list_len))));
    send_op(random_entry(KIND_INSERT, 5'd16));
    send_op(random_entry(KIND_INSERT, 5'd0));
    send_op(random_entry(KIND_INSERT, 5'd17));
    send_op(random_entry(KIND_READ, 5'd15));
    send_op(random_entry(KIND_READ, 5'd16));
    send_op(random_entry(KIND_REMOVE, 5'd16));
    send_op(random_entry(KIND_INSERT, 5'd15));
    send_op(random_entry(KIND_CLEAR, 5'd0));
  endtask

  // random operations under one mix of weights
  task automatic test_random_mix(input int n, input int ins_w, input int rem_w,
                                 input int rd_w);
    repeat (n) send_op(pick_op(ins_w, rem_w, rd_w));
  endtask

  // no idling on either side, one transfer per cycle when the block allows
  task automatic test_back_to_back(input int n);
    idling_on = 1'b0;
    stalling_on = 1'b0;
    test_random_mix(n, 45, 25, 28);
    idling_on = 1'b1;
    stalling_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < CAP; i++) list_slots[i] = BLANK_SLOT;
    list_len = 0;
    // reset held, once, before the tests
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_edge_entries();
    test_full_list();
    // growth-heavy mix drives the list toward full
    test_random_mix(150, 60, 15, 23);
    // removal-heavy mix drains it toward empty
    test_random_mix(150, 20, 55, 23);
    test_random_mix(200, 40, 35, 23);
    test_back_to_back(150);

    // drain: every owed result, then quiet cycles for strays
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d operations, %0d results compared, list length peaked at %0d",
             ops_sent, results_checked, peak_len);
    $display("tb: status ok %0d, invalid %0d, full %0d, empty %0d",
             status_tally[ST_OK], status_tally[ST_INVALID], status_tally[ST_FULL],
             status_tally[ST_EMPTY]);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/iirl_pkg.sv
hdl/iirl_ctrl.sv
hdl/iirl_dpath.sv
hdl/indexed_insert_remove_list_unit.sv
tb/tb.sv
